// ===== design/fbmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fbmt_pkg
// Shared geometry constants, codes, state and command types of the flash
// block map translation controller.
// ----------------------------------------------------------------------------
package fbmt_pkg;

    // Flash geometry.
    localparam int TOTAL_BLOCKS   = 64;
    localparam int PAGES_PER_BLK  = 32;
    localparam int INPLACE_PAGES  = 24;
    localparam int LOGICAL_BLOCKS = 48;

    localparam int TOTAL_PAGES = TOTAL_BLOCKS * PAGES_PER_BLK;
    localparam int SECTORS     = LOGICAL_BLOCKS * INPLACE_PAGES;

    // Field and index widths.
    localparam int SEC_W  = 12;
    localparam int PAGE_W = 11;
    localparam int TAG_W  = SEC_W + 1;
    localparam int BLK_W  = $clog2(TOTAL_BLOCKS);
    localparam int IDX_W  = $clog2(PAGES_PER_BLK);
    localparam int LB_W   = $clog2(LOGICAL_BLOCKS);
    localparam int OFF_W  = $clog2(INPLACE_PAGES);
    localparam int TPG_W  = $clog2(TOTAL_PAGES);

    // Division by the in-place page count through a reciprocal.
    localparam int DIV_SH    = 16;
    localparam int DIV_RECIP = ((1 << DIV_SH) + INPLACE_PAGES - 1) / INPLACE_PAGES;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int QW        = $clog2(((1 << SEC_W) - 1) / INPLACE_PAGES + 2);
    localparam int P2_W      = QW + OFF_W;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_COPY    = 2'd2,
        OP_ERASE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    // Block and page selects that form the tag memory address.
    typedef enum logic [1:0] {BS_PB, BS_SPARE, BS_NB} t_blk_sel;
    typedef enum logic [1:0] {PS_IDX, PS_OFF, PS_DOFF, PS_ZERO} t_pg_sel;
    typedef enum logic [1:0] {WD_MINE, WD_HOLD, WD_ZERO} t_wd_sel;
    typedef enum logic [2:0] {
        IX_HOLD, IX_INC, IX_DEC, IX_TOP, IX_INPLACE, IX_ZERO
    } t_idx_op;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_CHECK, S_MAP,
        S_RD_REQ, S_RD_CHK, S_RD_OFF_REQ, S_RD_OFF_CHK,
        S_ALLOC, S_WIP_REQ, S_WIP_CHK, S_OOP_REQ, S_OOP_CHK,
        S_M1_REQ, S_M1_CHK, S_M1_DIV1, S_M1_DIV2, S_M1_DREQ, S_M1_DCHK, S_M1_NEXT,
        S_M2_REQ, S_M2_CHK, S_M2_DREQ, S_M2_DCHK, S_M2_NEXT,
        S_ERASE, S_ERASE_EMIT, S_FINAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_src;
        logic     take_sector;
        logic     take_tag;
        logic     map_rd;
        logic     tag_rd;
        logic     tag_wr;
        logic     clr;
        t_blk_sel blk_sel;
        t_pg_sel  pg_sel;
        t_wd_sel  wd_sel;
        t_idx_op  idx_op;
        logic     hold_ld;
        logic     nb_clr;
        logic     nb_inc;
        logic     nb_from_spare;
        logic     alloc_commit;
        logic     merge_commit;
        logic     emit;
        t_op      op;
        logic     addr_en;
        logic     src_en;
        logic     found;
        t_status  status;
        logic     last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_write;
        logic in_range;
        logic mapped;
        logic tag_written;
        logic tag_mine;
        logic blk_free;
        logic nb_last;
        logic idx_top;
        logic idx_inplace;
        logic idx_inplace_m1;
        logic clr_last;
        logic out_ready;
    } t_dp_stat;

endpackage

// ===== design/fbmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbmt_ctrl
// Request sequencer: decodes reads and writes, runs the free page and free
// block scans, the merge into the spare block and the erase sweep.
// ----------------------------------------------------------------------------
module fbmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fbmt_pkg::t_dp_stat i_stat,
    output fbmt_pkg::t_dp_cmd  o_cmd,
    output logic              o_idle
);
    import fbmt_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd c;
    logic    rdy;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands. Side effects of a result, but for the
    // erase sweep, are only issued when the output register takes the result.
    always_comb begin
        c       = '0;
        n_state = r_state;
        rdy     = i_stat.out_ready;
        case (r_state)
            S_CLEAR: begin
                c.clr    = 1'b1;
                c.tag_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load  = 1'b1;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                c.div_start = 1'b1;
                n_state     = S_DIV2;
            end
            S_DIV2: begin
                c.take_sector = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.in_range) begin
                    c.emit   = rdy;
                    c.op     = i_stat.cmd_write ? OP_PROGRAM : OP_READ;
                    c.status = ST_RANGE;
                    c.last   = 1'b1;
                    if (rdy) n_state = S_IDLE;
                end else begin
                    c.map_rd = 1'b1;
                    n_state  = S_MAP;
                end
            end
            S_MAP: begin
                if (!i_stat.cmd_write) begin
                    if (!i_stat.mapped) begin
                        c.emit = rdy;
                        c.op   = OP_READ;
                        c.last = 1'b1;
                        if (rdy) n_state = S_IDLE;
                    end else begin
                        c.idx_op = IX_TOP;
                        n_state  = S_RD_REQ;
                    end
                end else if (!i_stat.mapped) begin
                    c.nb_clr = 1'b1;
                    n_state  = S_ALLOC;
                end else begin
                    n_state = S_WIP_REQ;
                end
            end
            // Read: newest out-of-place copy first, then the in-place page.
            S_RD_REQ: begin
                c.tag_rd = 1'b1;
                n_state  = S_RD_CHK;
            end
            S_RD_CHK: begin
                if (i_stat.tag_mine) begin
                    c.emit    = rdy;
                    c.op      = OP_READ;
                    c.addr_en = 1'b1;
                    c.found   = 1'b1;
                    c.last    = 1'b1;
                    if (rdy) n_state = S_IDLE;
                end else if (i_stat.idx_inplace) begin
                    n_state = S_RD_OFF_REQ;
                end else begin
                    c.idx_op = IX_DEC;
                    n_state  = S_RD_REQ;
                end
            end
            S_RD_OFF_REQ: begin
                c.tag_rd = 1'b1;
                c.pg_sel = PS_OFF;
                n_state  = S_RD_OFF_CHK;
            end
            S_RD_OFF_CHK: begin
                c.emit    = rdy;
                c.op      = OP_READ;
                c.pg_sel  = PS_OFF;
                c.addr_en = i_stat.tag_mine;
                c.found   = i_stat.tag_mine;
                c.last    = 1'b1;
                if (rdy) n_state = S_IDLE;
            end
            // First write to a logical block: scan for a free block.
            S_ALLOC: begin
                if (i_stat.blk_free) begin
                    c.emit         = rdy;
                    c.op           = OP_PROGRAM;
                    c.blk_sel      = BS_NB;
                    c.pg_sel       = PS_OFF;
                    c.addr_en      = 1'b1;
                    c.last         = 1'b1;
                    c.tag_wr       = rdy;
                    c.wd_sel       = WD_MINE;
                    c.alloc_commit = rdy;
                    if (rdy) n_state = S_IDLE;
                end else if (i_stat.nb_last) begin
                    c.emit   = rdy;
                    c.op     = OP_PROGRAM;
                    c.status = ST_NOFREE;
                    c.last   = 1'b1;
                    if (rdy) n_state = S_IDLE;
                end else begin
                    c.nb_inc = 1'b1;
                end
            end
            // Write to a mapped block: in-place page, then out-of-place pages.
            S_WIP_REQ: begin
                c.tag_rd = 1'b1;
                c.pg_sel = PS_OFF;
                n_state  = S_WIP_CHK;
            end
            S_WIP_CHK: begin
                c.pg_sel = PS_OFF;
                if (!i_stat.tag_written) begin
                    c.emit    = rdy;
                    c.op      = OP_PROGRAM;
                    c.addr_en = 1'b1;
                    c.last    = 1'b1;
                    c.tag_wr  = rdy;
                    if (rdy) n_state = S_IDLE;
                end else begin
                    c.idx_op = IX_INPLACE;
                    n_state  = S_OOP_REQ;
                end
            end
            S_OOP_REQ: begin
                c.tag_rd = 1'b1;
                n_state  = S_OOP_CHK;
            end
            S_OOP_CHK: begin
                if (!i_stat.tag_written) begin
                    c.emit    = rdy;
                    c.op      = OP_PROGRAM;
                    c.addr_en = 1'b1;
                    c.last    = 1'b1;
                    c.tag_wr  = rdy;
                    if (rdy) n_state = S_IDLE;
                end else if (i_stat.idx_top) begin
                    n_state = S_M1_REQ;
                end else begin
                    c.idx_op = IX_INC;
                    n_state  = S_OOP_REQ;
                end
            end
            // Merge, first pass: out-of-place pages from the top down.
            S_M1_REQ: begin
                c.tag_rd = 1'b1;
                n_state  = S_M1_CHK;
            end
            S_M1_CHK: begin
                if (i_stat.tag_written && !i_stat.tag_mine) begin
                    c.hold_ld = 1'b1;
                    n_state   = S_M1_DIV1;
                end else begin
                    n_state = S_M1_NEXT;
                end
            end
            S_M1_DIV1: begin
                c.div_start = 1'b1;
                c.div_src   = 1'b1;
                n_state     = S_M1_DIV2;
            end
            S_M1_DIV2: begin
                c.take_tag = 1'b1;
                n_state    = S_M1_DREQ;
            end
            S_M1_DREQ: begin
                c.tag_rd  = 1'b1;
                c.blk_sel = BS_SPARE;
                c.pg_sel  = PS_DOFF;
                n_state   = S_M1_DCHK;
            end
            S_M1_DCHK: begin
                c.blk_sel = BS_SPARE;
                c.pg_sel  = PS_DOFF;
                if (!i_stat.tag_written) begin
                    c.emit    = rdy;
                    c.op      = OP_COPY;
                    c.addr_en = 1'b1;
                    c.src_en  = 1'b1;
                    c.tag_wr  = rdy;
                    c.wd_sel  = WD_HOLD;
                    if (rdy) n_state = S_M1_NEXT;
                end else begin
                    n_state = S_M1_NEXT;
                end
            end
            S_M1_NEXT: begin
                if (i_stat.idx_inplace) begin
                    c.idx_op = IX_ZERO;
                    n_state  = S_M2_REQ;
                end else begin
                    c.idx_op = IX_DEC;
                    n_state  = S_M1_REQ;
                end
            end
            // Merge, second pass: in-place pages into the same slots.
            S_M2_REQ: begin
                c.tag_rd = 1'b1;
                n_state  = S_M2_CHK;
            end
            S_M2_CHK: begin
                if (i_stat.tag_written && !i_stat.tag_mine) begin
                    c.hold_ld = 1'b1;
                    n_state   = S_M2_DREQ;
                end else begin
                    n_state = S_M2_NEXT;
                end
            end
            S_M2_DREQ: begin
                c.tag_rd  = 1'b1;
                c.blk_sel = BS_SPARE;
                n_state   = S_M2_DCHK;
            end
            S_M2_DCHK: begin
                c.blk_sel = BS_SPARE;
                if (!i_stat.tag_written) begin
                    c.emit    = rdy;
                    c.op      = OP_COPY;
                    c.addr_en = 1'b1;
                    c.src_en  = 1'b1;
                    c.tag_wr  = rdy;
                    c.wd_sel  = WD_HOLD;
                    if (rdy) n_state = S_M2_NEXT;
                end else begin
                    n_state = S_M2_NEXT;
                end
            end
            S_M2_NEXT: begin
                if (i_stat.idx_inplace_m1) begin
                    c.idx_op = IX_ZERO;
                    n_state  = S_ERASE;
                end else begin
                    c.idx_op = IX_INC;
                    n_state  = S_M2_REQ;
                end
            end
            // Erase the old block, one page tag a cycle.
            S_ERASE: begin
                c.tag_wr = 1'b1;
                c.wd_sel = WD_ZERO;
                if (i_stat.idx_top) begin
                    n_state = S_ERASE_EMIT;
                end else begin
                    c.idx_op = IX_INC;
                end
            end
            S_ERASE_EMIT: begin
                c.emit    = rdy;
                c.op      = OP_ERASE;
                c.pg_sel  = PS_ZERO;
                c.addr_en = 1'b1;
                if (rdy) begin
                    c.merge_commit  = 1'b1;
                    c.nb_from_spare = 1'b1;
                    n_state         = S_FINAL;
                end
            end
            S_FINAL: begin
                c.emit    = rdy;
                c.op      = OP_PROGRAM;
                c.blk_sel = BS_NB;
                c.pg_sel  = PS_OFF;
                c.addr_en = 1'b1;
                c.last    = 1'b1;
                c.tag_wr  = rdy;
                if (rdy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = c;
    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== design/fbmt_dp.sv =====
// ----------------------------------------------------------------------------
// fbmt_dp
// Datapath: request registers, reciprocal divider, block map memory, page
// tag memory, block usage flags and the output register.
// ----------------------------------------------------------------------------
module fbmt_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fbmt_pkg::t_dp_cmd          i_cmd,
    input  logic                      i_command,
    input  logic [fbmt_pkg::SEC_W-1:0] i_sector,
    input  logic                      i_out_stall,
    output fbmt_pkg::t_dp_stat         o_stat,
    output logic                      o_out_valid,
    output logic [1:0]                o_operation,
    output logic [fbmt_pkg::PAGE_W-1:0] o_page_address,
    output logic [fbmt_pkg::PAGE_W-1:0] o_source_page,
    output logic                      o_found,
    output logic [1:0]                o_status,
    output logic                      o_last
);
    import fbmt_pkg::*;

    // Request and scan registers.
    logic             r_cmd;
    logic [SEC_W-1:0] r_sector;
    logic [LB_W-1:0]  r_lb;
    logic [OFF_W-1:0] r_off;
    logic [OFF_W-1:0] r_doff;
    logic [BLK_W-1:0] r_pb;
    logic             r_mapped;
    logic [BLK_W-1:0] r_nb;
    logic [IDX_W-1:0] r_idx;
    logic [TAG_W-1:0] r_hold;
    logic [TAG_W-1:0] r_tag_q;
    logic [TPG_W-1:0] r_clr_cnt;

    // Persistent mapping state.
    logic [BLK_W-1:0]    mem_map [LOGICAL_BLOCKS];
    logic [TAG_W-1:0]    mem_tag [TOTAL_PAGES];
    logic [LOGICAL_BLOCKS-1:0] r_map_vld;
    logic [TOTAL_BLOCKS-1:0]   r_used;
    logic [BLK_W-1:0]    r_spare;

    // Output register.
    logic             r_out_valid;
    t_op              r_op;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] r_src;
    logic             r_found;
    t_status          r_status;
    logic             r_last;

    // Divider registers.
    logic [SEC_W-1:0] r_div_x;
    logic [QW-1:0]    r_q0;

    logic [SEC_W-1:0]         div_x;
    logic [SEC_W+RECIP_W-1:0] div_prod;
    logic [P2_W-1:0]          div_p2;
    logic [P2_W-1:0]          div_diff;
    logic                     div_over;
    logic [QW-1:0]            div_q;
    logic [OFF_W-1:0]         div_rem;

    logic [BLK_W-1:0] blk_v;
    logic [IDX_W-1:0] pg_v;
    logic [TPG_W-1:0] tag_addr;
    logic [TPG_W-1:0] src_addr;
    logic [TAG_W-1:0] tag_wd;
    logic [TAG_W-1:0] mine;
    logic             out_ready;

    assign mine      = {1'b1, r_sector};
    assign out_ready = !r_out_valid || !i_out_stall;

    // Divide by the in-place page count: reciprocal estimate, then one fix-up.
    assign div_x    = i_cmd.div_src ? r_hold[SEC_W-1:0] : r_sector;
    assign div_prod = (SEC_W+RECIP_W)'(div_x) * (SEC_W+RECIP_W)'(DIV_RECIP);
    assign div_p2   = P2_W'(r_q0) * P2_W'(INPLACE_PAGES);
    assign div_over = div_p2 > P2_W'(r_div_x);

    always_comb begin
        div_diff = P2_W'(r_div_x) - div_p2;
        div_q    = r_q0;
        if (div_over) begin
            div_diff = div_diff + P2_W'(INPLACE_PAGES);
            div_q    = r_q0 - QW'(1);
        end
        div_rem = div_diff[OFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_x <= div_x;
            r_q0    <= div_prod[DIV_SH +: QW];
        end
    end

    // Tag memory address from the block and page selects.
    always_comb begin
        case (i_cmd.blk_sel)
            BS_PB:    blk_v = r_pb;
            BS_SPARE: blk_v = r_spare;
            BS_NB:    blk_v = r_nb;
            default:  blk_v = r_pb;
        endcase
        case (i_cmd.pg_sel)
            PS_IDX:  pg_v = r_idx;
            PS_OFF:  pg_v = IDX_W'(r_off);
            PS_DOFF: pg_v = IDX_W'(r_doff);
            PS_ZERO: pg_v = '0;
            default: pg_v = r_idx;
        endcase
        case (i_cmd.wd_sel)
            WD_MINE: tag_wd = mine;
            WD_HOLD: tag_wd = r_hold;
            WD_ZERO: tag_wd = '0;
            default: tag_wd = '0;
        endcase
        tag_addr = TPG_W'(int'(blk_v) * PAGES_PER_BLK + int'(pg_v));
        src_addr = TPG_W'(int'(r_pb) * PAGES_PER_BLK + int'(r_idx));
        if (i_cmd.clr) begin
            tag_addr = r_clr_cnt;
            tag_wd   = '0;
        end
    end

    // Page tag memory, single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tag_wr) begin
            mem_tag[tag_addr] <= tag_wd;
        end
        if (i_cmd.tag_rd) begin
            r_tag_q <= mem_tag[tag_addr];
        end
    end

    // Block map memory, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_commit) begin
            mem_map[r_lb] <= r_nb;
        end else if (i_cmd.merge_commit) begin
            mem_map[r_lb] <= r_spare;
        end
        if (i_cmd.map_rd) begin
            r_pb     <= mem_map[r_lb];
            r_mapped <= r_map_vld[r_lb];
        end
    end

    // Request, scan and held-tag registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_sector <= i_sector;
        end
        if (i_cmd.take_sector) begin
            r_lb  <= div_q[LB_W-1:0];
            r_off <= div_rem;
        end
        if (i_cmd.take_tag) begin
            r_doff <= div_rem;
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_tag_q;
        end
        if (i_cmd.nb_clr) begin
            r_nb <= '0;
        end else if (i_cmd.nb_inc) begin
            r_nb <= r_nb + BLK_W'(1);
        end else if (i_cmd.nb_from_spare) begin
            r_nb <= r_spare;
        end
        case (i_cmd.idx_op)
            IX_HOLD:    r_idx <= r_idx;
            IX_INC:     r_idx <= r_idx + IDX_W'(1);
            IX_DEC:     r_idx <= r_idx - IDX_W'(1);
            IX_TOP:     r_idx <= IDX_W'(PAGES_PER_BLK - 1);
            IX_INPLACE: r_idx <= IDX_W'(INPLACE_PAGES);
            IX_ZERO:    r_idx <= '0;
            default:    r_idx <= r_idx;
        endcase
    end

    // Mapping flags, spare block and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_used    <= '0;
            r_spare   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + TPG_W'(1);
            end
            if (i_cmd.alloc_commit) begin
                r_used[r_nb]    <= 1'b1;
                r_map_vld[r_lb] <= 1'b1;
            end
            if (i_cmd.merge_commit) begin
                r_used[r_spare] <= 1'b1;
                r_used[r_pb]    <= 1'b0;
                r_spare         <= r_pb;
            end
        end
    end

    // Output register: loads a result, drains when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_ready) begin
            r_op     <= i_cmd.op;
            r_page   <= i_cmd.addr_en ? PAGE_W'(tag_addr) : '0;
            r_src    <= i_cmd.src_en ? PAGE_W'(src_addr) : '0;
            r_found  <= i_cmd.found;
            r_status <= i_cmd.status;
            r_last   <= i_cmd.last;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.cmd_write      = r_cmd;
        o_stat.in_range       = r_sector < SEC_W'(SECTORS);
        o_stat.mapped         = r_mapped;
        o_stat.tag_written    = r_tag_q[TAG_W-1];
        o_stat.tag_mine       = (r_tag_q == mine);
        o_stat.blk_free       = !r_used[r_nb] && (r_nb != r_spare);
        o_stat.nb_last        = (r_nb == BLK_W'(TOTAL_BLOCKS - 1));
        o_stat.idx_top        = (r_idx == IDX_W'(PAGES_PER_BLK - 1));
        o_stat.idx_inplace    = (r_idx == IDX_W'(INPLACE_PAGES));
        o_stat.idx_inplace_m1 = (r_idx == IDX_W'(INPLACE_PAGES - 1));
        o_stat.clr_last       = (r_clr_cnt == TPG_W'(TOTAL_PAGES - 1));
        o_stat.out_ready      = out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_operation    = r_op;
    assign o_page_address = r_page;
    assign o_source_page  = r_src;
    assign o_found        = r_found;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule

// ===== design/flash_block_map_translation_top.sv =====
// ----------------------------------------------------------------------------
// flash_block_map_translation_top
// Block-mapped flash translation controller with in-place and out-of-place
// pages, a spare block for merges and a page tag mirror.
// ----------------------------------------------------------------------------
// Usage:
// A request (read or write of one logical sector) is transferred on the input
// channel when i_in_valid is high and o_in_stall is low. One request is worked
// on at a time; o_in_stall stays high until its last result has been loaded
// into the output register.
// Each request produces one or more results on the output channel, which is
// a single output register; o_last marks the final result of a request.
// Reads and writes check the out-of-place pages one at a time through the
// single tag memory port. A first write to a logical block scans for a
// free block, one block a cycle. A merge reads each page of the old block
// through the tag memory port and copies the pages of other sectors that
// still hold data into free slots of the spare block, then erases the old
// block. The next request can be taken in the cycle after the last result
// is loaded. After reset the tag memory is cleared one page a cycle, with
// the input stalled. When the receiver stalls a full output register, the
// sequencer waits with the pending result and no state changes until it is
// taken.
// ----------------------------------------------------------------------------
module flash_block_map_translation_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [fbmt_pkg::SEC_W-1:0]  i_sector,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_operation,
    output logic [fbmt_pkg::PAGE_W-1:0] o_page_address,
    output logic [fbmt_pkg::PAGE_W-1:0] o_source_page,
    output logic                        o_found,
    output logic [1:0]                  o_status,
    output logic                        o_last
);
    import fbmt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     idle;

    // Request sequencer.
    fbmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    // Datapath with the mapping memories and the output register.
    fbmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_command),
        .i_sector       (i_sector),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_operation    (o_operation),
        .o_page_address (o_page_address),
        .o_source_page  (o_source_page),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    assign o_in_stall = !idle;

endmodule

// ===== tb/fbmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmt_checker
// Watches both channels of the flash block map translation controller. It
// keeps its own copy of the block map, free marks, spare block and page tags,
// predicts the results of every accepted request and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fbmt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_command,
    input  logic [fbmt_pkg::SEC_W-1:0]  i_sector,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [1:0]                  i_operation,
    input  logic [fbmt_pkg::PAGE_W-1:0] i_page_address,
    input  logic [fbmt_pkg::PAGE_W-1:0] i_source_page,
    input  logic                        i_found,
    input  logic [1:0]                  i_status,
    input  logic                        i_last,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_merges,
    output int                          o_results
);
    import fbmt_pkg::*;

    typedef struct packed {
        t_op              op;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] src;
        logic              found;
        t_status           status;
        logic              last;
    } t_flash_result;

    // Mirror of the controller state.
    logic                map_valid [LOGICAL_BLOCKS];
    logic [BLK_W-1:0]    map_block [LOGICAL_BLOCKS];
    logic                blk_used  [TOTAL_BLOCKS];
    logic [BLK_W-1:0]    spare;
    logic [TAG_W-1:0]    tag       [TOTAL_PAGES];

    t_flash_result       expected_results [$];
    t_flash_result       req_results [$];

    assign o_pending = expected_results.size();

    initial begin
        o_errors  = 0;
        o_merges  = 0;
        o_results = 0;
    end

    task automatic add_result(t_op op, int page, int src, logic found, t_status st);
        t_flash_result r;
        r.op     = op;
        r.page   = page[PAGE_W-1:0];
        r.src    = src[PAGE_W-1:0];
        r.found  = found;
        r.status = st;
        r.last   = 1'b0;
        req_results.push_back(r);
    endtask

    // Read: newest out-of-place copy first, then the in-place page.
    task automatic predict_read(int sec);
        int              lb;
        int              off;
        int              base;
        logic [TAG_W-1:0] want;
        logic            hit;
        lb   = sec / INPLACE_PAGES;
        off  = sec % INPLACE_PAGES;
        want = {1'b1, sec[SEC_W-1:0]};
        hit  = 1'b0;
        if (!map_valid[lb]) begin
            add_result(OP_READ, 0, 0, 1'b0, ST_OK);
        end else begin
            base = int'(map_block[lb]) * PAGES_PER_BLK;
            for (int i = PAGES_PER_BLK - 1; i >= INPLACE_PAGES && !hit; i--) begin
                if (tag[base + i] == want) begin
                    add_result(OP_READ, base + i, 0, 1'b1, ST_OK);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (tag[base + off] == want)
                    add_result(OP_READ, base + off, 0, 1'b1, ST_OK);
                else
                    add_result(OP_READ, 0, 0, 1'b0, ST_OK);
            end
        end
    endtask

    // Write: allocate, in place, out of place, or merge into the spare block.
    task automatic predict_write(int sec);
        int              lb;
        int              off;
        int              pb;
        int              base;
        int              nb;
        int              nbase;
        int              dst;
        logic [TAG_W-1:0] mine;
        logic [TAG_W-1:0] t;
        logic            done;
        lb   = sec / INPLACE_PAGES;
        off  = sec % INPLACE_PAGES;
        mine = {1'b1, sec[SEC_W-1:0]};
        done = 1'b0;
        if (!map_valid[lb]) begin
            nb = -1;
            for (int b = 0; b < TOTAL_BLOCKS && nb < 0; b++)
                if (b != int'(spare) && !blk_used[b])
                    nb = b;
            if (nb < 0) begin
                add_result(OP_PROGRAM, 0, 0, 1'b0, ST_NOFREE);
            end else begin
                blk_used[nb]  = 1'b1;
                map_valid[lb] = 1'b1;
                map_block[lb] = nb[BLK_W-1:0];
                tag[nb * PAGES_PER_BLK + off] = mine;
                add_result(OP_PROGRAM, nb * PAGES_PER_BLK + off, 0, 1'b0, ST_OK);
            end
        end else begin
            pb   = int'(map_block[lb]);
            base = pb * PAGES_PER_BLK;
            if (!tag[base + off][TAG_W-1]) begin
                tag[base + off] = mine;
                add_result(OP_PROGRAM, base + off, 0, 1'b0, ST_OK);
                done = 1'b1;
            end
            for (int i = INPLACE_PAGES; i < PAGES_PER_BLK && !done; i++) begin
                if (!tag[base + i][TAG_W-1]) begin
                    tag[base + i] = mine;
                    add_result(OP_PROGRAM, base + i, 0, 1'b0, ST_OK);
                    done = 1'b1;
                end
            end
            if (!done) begin
                o_merges++;
                nb    = int'(spare);
                nbase = nb * PAGES_PER_BLK;
                // Newest out-of-place copies win their in-place slot.
                for (int i = PAGES_PER_BLK - 1; i >= INPLACE_PAGES; i--) begin
                    t = tag[base + i];
                    if (t[TAG_W-1] && t != mine) begin
                        dst = nbase + int'(t[SEC_W-1:0]) % INPLACE_PAGES;
                        if (!tag[dst][TAG_W-1]) begin
                            tag[dst] = t;
                            add_result(OP_COPY, dst, base + i, 1'b0, ST_OK);
                        end
                    end
                end
                for (int i = 0; i < INPLACE_PAGES; i++) begin
                    t = tag[base + i];
                    if (t[TAG_W-1] && t != mine && !tag[nbase + i][TAG_W-1]) begin
                        tag[nbase + i] = t;
                        add_result(OP_COPY, nbase + i, base + i, 1'b0, ST_OK);
                    end
                end
                blk_used[nb]  = 1'b1;
                map_block[lb] = nb[BLK_W-1:0];
                for (int i = 0; i < PAGES_PER_BLK; i++)
                    tag[base + i] = '0;
                blk_used[pb] = 1'b0;
                spare        = pb[BLK_W-1:0];
                add_result(OP_ERASE, base, 0, 1'b0, ST_OK);
                tag[nbase + off] = mine;
                add_result(OP_PROGRAM, nbase + off, 0, 1'b0, ST_OK);
            end
        end
    endtask

    task automatic predict_request(logic cmd, logic [SEC_W-1:0] sec);
        t_flash_result r;
        req_results.delete();
        if (int'(sec) >= SECTORS)
            add_result(cmd ? OP_PROGRAM : OP_READ, 0, 0, 1'b0, ST_RANGE);
        else if (cmd)
            predict_write(int'(sec));
        else
            predict_read(int'(sec));
        r = req_results.pop_back();
        r.last = 1'b1;
        req_results.push_back(r);
        foreach (req_results[k])
            expected_results.push_back(req_results[k]);
    endtask

    // Channel monitor: predict on request transfers, compare on result transfers.
    always @(posedge i_clk) begin
        t_flash_result exp_r;
        t_flash_result act_r;
        if (!i_rst_n) begin
            for (int i = 0; i < LOGICAL_BLOCKS; i++) begin
                map_valid[i] = 1'b0;
                map_block[i] = '0;
            end
            for (int i = 0; i < TOTAL_BLOCKS; i++)
                blk_used[i] = 1'b0;
            for (int i = 0; i < TOTAL_PAGES; i++)
                tag[i] = '0;
            spare = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_request(i_command, i_sector);
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                act_r.op     = t_op'(i_operation);
                act_r.page   = i_page_address;
                act_r.src    = i_source_page;
                act_r.found  = i_found;
                act_r.status = t_status'(i_status);
                act_r.last   = i_last;
                if (expected_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result op=%0d page=%0d src=%0d found=%0b st=%0d last=%0b",
                             $time, act_r.op, act_r.page, act_r.src, act_r.found,
                             act_r.status, act_r.last);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != act_r) begin
                        o_errors++;
                        $display("%0t: mismatch expected op=%0d page=%0d src=%0d found=%0b st=%0d last=%0b",
                                 $time, exp_r.op, exp_r.page, exp_r.src, exp_r.found,
                                 exp_r.status, exp_r.last);
                        $display("%0t:          actual   op=%0d page=%0d src=%0d found=%0b st=%0d last=%0b",
                                 $time, act_r.op, act_r.page, act_r.src, act_r.found,
                                 act_r.status, act_r.last);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/flash_block_map_translation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_block_map_translation_top_tb
// Drives sector reads and writes into the controller with random gaps and
// result-side stalls, including one long hold-off, and takes the verdict
// from the checker that predicts every command the controller emits.
// ----------------------------------------------------------------------------
module flash_block_map_translation_top_tb;
    import fbmt_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              command;
    logic [SEC_W-1:0]  sector;
    logic              out_valid;
    logic              stall_rnd;
    logic              stall_hold;
    logic              out_stall;
    logic [1:0]        operation;
    logic [PAGE_W-1:0] page_address;
    logic [PAGE_W-1:0] source_page;
    logic              found;
    logic [1:0]        status;
    logic              last;
    int                errors;
    int                pending;
    int                merges;
    int                results;
    int                sent;
    logic              burst;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    assign out_stall = stall_rnd | stall_hold;

    flash_block_map_translation_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_sector       (sector),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_operation    (operation),
        .o_page_address (page_address),
        .o_source_page  (source_page),
        .o_found        (found),
        .o_status       (status),
        .o_last         (last)
    );

    fbmt_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_sector       (sector),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_operation    (operation),
        .i_page_address (page_address),
        .i_source_page  (source_page),
        .i_found        (found),
        .i_status       (status),
        .i_last         (last),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_merges       (merges),
        .o_results      (results)
    );

    // 10 ns clock.
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // One request transfer after a random gap; zero gaps during bursts.
    task automatic send_request(logic cmd, int sec);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        sector   <= sec[SEC_W-1:0];
        forever begin
            #1;
            if (!in_stall) begin
                @(posedge clk);
                break;
            end
            @(negedge clk);
        end
        sent++;
    endtask

    // Result side: random stall before each transfer.
    initial begin
        int n;
        stall_rnd = 1'b1;
        @(posedge rst_n);
        forever begin
            n = burst ? 0 : $urandom_range(0, 12);
            repeat (n) begin
                @(negedge clk);
                stall_rnd <= 1'b1;
            end
            @(negedge clk);
            stall_rnd <= 1'b0;
            forever begin
                #1;
                if (out_valid && !out_stall) begin
                    @(posedge clk);
                    break;
                end
                @(negedge clk);
            end
        end
    end

    // One long hold-off on the result side while requests keep coming.
    initial begin
        stall_hold = 1'b0;
        wait (sent >= 60);
        @(negedge clk);
        stall_hold <= 1'b1;
        repeat (400) @(negedge clk);
        stall_hold <= 1'b0;
    end

    // Stimulus and verdict.
    initial begin
        int lb;
        int off;
        int sel;
        logic cmd;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_READ;
        sector   = '0;
        sent     = 0;
        burst    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: unmapped read, allocation, in-place, out-of-place, merge, out-of-range.
        send_request(CMD_READ, 0);
        send_request(CMD_WRITE, 0);
        send_request(CMD_READ, 0);
        send_request(CMD_READ, 1);
        send_request(CMD_WRITE, 1);
        for (int i = 0; i < 9; i++)
            send_request(CMD_WRITE, 0);
        send_request(CMD_READ, 0);
        send_request(CMD_READ, 1);
        send_request(CMD_WRITE, SECTORS - 1);
        send_request(CMD_READ, SECTORS - 1);
        send_request(CMD_READ, SECTORS);
        send_request(CMD_WRITE, SECTORS);
        send_request(CMD_READ, (1 << SEC_W) - 1);
        send_request(CMD_WRITE, (1 << SEC_W) - 1);
        send_request(CMD_WRITE, 2 * INPLACE_PAGES + 5);

        // Random: mostly traffic on a few hot blocks so that merges recur.
        for (int i = 0; i < 160; i++) begin
            if (i % 20 == 0)
                burst = ($urandom_range(0, 2) == 0);
            sel = $urandom_range(0, 99);
            cmd = ($urandom_range(0, 99) < 65) ? CMD_WRITE : CMD_READ;
            if (sel < 80) begin
                case ($urandom_range(0, 4))
                    0: lb = 0;
                    1: lb = 1;
                    2: lb = 2;
                    3: lb = LOGICAL_BLOCKS - 1;
                    default: lb = $urandom_range(0, LOGICAL_BLOCKS - 1);
                endcase
                off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, INPLACE_PAGES - 1)
                                                  : $urandom_range(0, 3);
                send_request(cmd, lb * INPLACE_PAGES + off);
            end else if (sel < 90) begin
                send_request(cmd, $urandom_range(SECTORS, (1 << SEC_W) - 1));
            end else begin
                send_request(cmd, $urandom_range(0, (1 << SEC_W) - 1));
            end
        end
        burst = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (250) @(posedge clk);
        $display("Sent %0d requests, checked %0d results, %0d block merges.",
                 sent, results, merges);
        $display("Covered unmapped and out-of-range access, out-of-place updates and merges.");
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fbmt_pkg.sv
design/fbmt_ctrl.sv
design/fbmt_dp.sv
design/flash_block_map_translation_top.sv
tb/fbmt_checker.sv
tb/flash_block_map_translation_top_tb.sv
